// ===== hdl/bff_pkg.sv =====
// ----------------------------------------------------------------------------
// bff_pkg
// Shared types and codes for the boundary flood fill frame store.
// ----------------------------------------------------------------------------
package bff_pkg;

	// Command codes as they arrive on the action port
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_FILL  = 2'd2;

	// Configuration register indexes
	localparam logic REG_FILL     = 1'b0;
	localparam logic REG_BOUNDARY = 1'b1;

	// Register reset values
	localparam logic [23:0] FILL_RESET     = 24'h0000FF;
	localparam logic [23:0] BOUNDARY_RESET = 24'hFF0000;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_FILL,
		OP_NOP
	} op_t;

	// Neighbor visit order, as pushed (pops come back reversed)
	typedef enum logic [1:0] {
		NB_DOWN,
		NB_UP,
		NB_LEFT,
		NB_RIGHT
	} nbr_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_RDW,
		B_SEED,
		B_POP,
		B_POPW,
		B_CHK,
		B_NB,
		B_NBW
	} bstate_t;

	// Classified request handed from front to back
	typedef struct packed {
		op_t         op;
		logic        in_frame;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [23:0] colour;
	} cmd_t;

endpackage

// ===== hdl/bff_ram.sv =====
// ----------------------------------------------------------------------------
// bff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bff_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bff_front.sv =====
// ----------------------------------------------------------------------------
// bff_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bff_front #(
	parameter int FRAME_WIDTH  = 256,
	parameter int FRAME_HEIGHT = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     action,
	input  logic [7:0]     x_coord,
	input  logic [7:0]     y_coord,
	input  logic [23:0]    pixel_colour,
	input  logic           clearing,
	output logic           busy,
	output bff_pkg::cmd_t  cmd,
	output logic           cmd_valid,
	input  logic           cmd_pop
);
	import bff_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;

	// Classify the incoming request
	always_comb begin
		cls.x        = x_coord;
		cls.y        = y_coord;
		cls.colour   = pixel_colour;
		cls.in_frame = (32'(x_coord) < FRAME_WIDTH) && (32'(y_coord) < FRAME_HEIGHT);
		case (action)
			ACT_WRITE: cls.op = OP_WRITE;
			ACT_READ:  cls.op = OP_READ;
			ACT_FILL:  cls.op = OP_FILL;
			default:   cls.op = OP_NOP;
		endcase
	end

	assign busy      = (cnt_q == 2'd2) || clearing;
	assign push      = start && !busy;
	assign cmd       = q_q[rp_q];
	assign cmd_valid = (cnt_q != 2'd0);

	// Hold queued requests
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cls;
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

// ===== hdl/bff_back.sv =====
// ----------------------------------------------------------------------------
// bff_back
// Executes requests against the frame store: pixel access and stack fill.
// ----------------------------------------------------------------------------
module bff_back #(
	parameter int FRAME_WIDTH  = 256,
	parameter int FRAME_HEIGHT = 256,
	parameter int STACK_DEPTH  = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bff_pkg::cmd_t  cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	input  logic [23:0]    fill_colour,
	input  logic [23:0]    boundary_colour,
	output logic           clearing,
	output logic           done,
	output logic [23:0]    read_colour,
	output logic [16:0]    filled_count,
	output logic           status
);
	import bff_pkg::*;

	localparam int XW  = $clog2(FRAME_WIDTH);
	localparam int YW  = $clog2(FRAME_HEIGHT);
	localparam int NPX = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW  = $clog2(NPX);
	localparam int PW  = XW + YW;
	localparam int SIW = $clog2(STACK_DEPTH);
	localparam int SPW = SIW + 1;

	bstate_t        state_q, state_d;
	logic [AW-1:0]  clr_q, clr_d;
	logic [XW-1:0]  x_q, x_d, nx_q, nx_d, nbx;
	logic [YW-1:0]  y_q, y_d, ny_q, ny_d, nby;
	nbr_t           k_q, k_d;
	logic [SPW-1:0] sp_q, sp_d, sp_m1;
	logic [16:0]    cnt_q, cnt_d;
	logic           done_q, done_d;
	logic [23:0]    rd_q, rd_d;
	logic           st_q, st_d;
	logic           nb_ok;

	logic           f_we;
	logic [AW-1:0]  f_waddr, f_raddr;
	logic [23:0]    f_wdata, f_rdata;
	logic           s_we;
	logic [SIW-1:0] s_waddr, s_raddr;
	logic [PW-1:0]  s_wdata, s_rdata;
	logic           paint_ok;

	function automatic logic [AW-1:0] faddr(input logic [YW-1:0] y, input logic [XW-1:0] x);
		faddr = AW'(32'(y) * FRAME_WIDTH + 32'(x));
	endfunction

	bff_ram #(.WIDTH(24), .DEPTH(NPX)) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	bff_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign paint_ok     = (f_rdata != boundary_colour) && (f_rdata != fill_colour);
	assign sp_m1        = sp_q - SPW'(1);
	assign clearing     = (state_q == B_CLEAR);
	assign done         = done_q;
	assign read_colour  = rd_q;
	assign filled_count = cnt_q;
	assign status       = st_q;

	// Pick the current neighbor and check that it lies in the frame
	always_comb begin
		nbx   = x_q;
		nby   = y_q;
		nb_ok = 1'b0;
		case (k_q)
			NB_DOWN: begin
				nby   = y_q - YW'(1);
				nb_ok = (y_q != '0);
			end
			NB_UP: begin
				nby   = y_q + YW'(1);
				nb_ok = (32'(y_q) + 32'd1) < FRAME_HEIGHT;
			end
			NB_LEFT: begin
				nbx   = x_q - XW'(1);
				nb_ok = (x_q != '0);
			end
			NB_RIGHT: begin
				nbx   = x_q + XW'(1);
				nb_ok = (32'(x_q) + 32'd1) < FRAME_WIDTH;
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// Next state, memory controls and results
	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		x_d     = x_q;
		y_d     = y_q;
		nx_d    = nx_q;
		ny_d    = ny_q;
		k_d     = k_q;
		sp_d    = sp_q;
		cnt_d   = cnt_q;
		done_d  = 1'b0;
		rd_d    = rd_q;
		st_d    = st_q;
		cmd_pop = 1'b0;
		f_we    = 1'b0;
		f_waddr = faddr(y_q, x_q);
		f_wdata = fill_colour;
		f_raddr = faddr(y_q, x_q);
		s_we    = 1'b0;
		s_waddr = sp_q[SIW-1:0];
		s_wdata = {ny_q, nx_q};
		s_raddr = sp_m1[SIW-1:0];
		case (state_q)
			B_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = clr_q;
				f_wdata = '0;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(NPX - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cnt_d   = '0;
					rd_d    = '0;
					st_d    = 1'b0;
					x_d     = XW'(cmd.x);
					y_d     = YW'(cmd.y);
					f_waddr = faddr(YW'(cmd.y), XW'(cmd.x));
					f_raddr = faddr(YW'(cmd.y), XW'(cmd.x));
					f_wdata = cmd.colour;
					case (cmd.op)
						OP_WRITE: begin
							f_we   = cmd.in_frame;
							done_d = 1'b1;
						end
						OP_READ: begin
							if (cmd.in_frame) begin
								state_d = B_RDW;
							end else begin
								done_d = 1'b1;
							end
						end
						OP_FILL: begin
							sp_d = '0;
							if (cmd.in_frame) begin
								state_d = B_SEED;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			B_RDW: begin
				rd_d    = f_rdata;
				done_d  = 1'b1;
				state_d = B_IDLE;
			end
			B_SEED: begin
				if (paint_ok) begin
					s_we    = 1'b1;
					s_waddr = '0;
					s_wdata = {y_q, x_q};
					sp_d    = SPW'(1);
					state_d = B_POP;
				end else begin
					done_d  = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_POP: begin
				if (sp_q == '0) begin
					done_d  = 1'b1;
					state_d = B_IDLE;
				end else begin
					sp_d    = sp_m1;
					state_d = B_POPW;
				end
			end
			B_POPW: begin
				y_d     = s_rdata[PW-1:XW];
				x_d     = s_rdata[XW-1:0];
				f_raddr = faddr(s_rdata[PW-1:XW], s_rdata[XW-1:0]);
				state_d = B_CHK;
			end
			B_CHK: begin
				if (paint_ok) begin
					f_we    = 1'b1;
					cnt_d   = (&cnt_q) ? cnt_q : cnt_q + 17'd1;
					k_d     = NB_DOWN;
					state_d = B_NB;
				end else begin
					state_d = B_POP;
				end
			end
			B_NB: begin
				f_raddr = faddr(nby, nbx);
				nx_d    = nbx;
				ny_d    = nby;
				if (nb_ok) begin
					state_d = B_NBW;
				end else if (k_q == NB_RIGHT) begin
					state_d = B_POP;
				end else begin
					k_d = nbr_t'(2'(k_q) + 2'd1);
				end
			end
			B_NBW: begin
				if (paint_ok && (32'(sp_q) >= STACK_DEPTH)) begin
					// Stack full: stop the fill and flag it
					st_d    = 1'b1;
					done_d  = 1'b1;
					state_d = B_IDLE;
				end else begin
					if (paint_ok) begin
						s_we = 1'b1;
						sp_d = sp_q + SPW'(1);
					end
					if (k_q == NB_RIGHT) begin
						state_d = B_POP;
					end else begin
						k_d     = nbr_t'(2'(k_q) + 2'd1);
						state_d = B_NB;
					end
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			sp_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			sp_q    <= sp_d;
			done_q  <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		x_q   <= x_d;
		y_q   <= y_d;
		nx_q  <= nx_d;
		ny_q  <= ny_d;
		k_q   <= k_d;
		cnt_q <= cnt_d;
		rd_q  <= rd_d;
		st_q  <= st_d;
	end

endmodule

// ===== hdl/boundary_flood_fill.sv =====
// ----------------------------------------------------------------------------
// boundary_flood_fill
// Frame store with pixel write, pixel read and four-connected boundary fill.
// ----------------------------------------------------------------------------
// After reset the frame store is cleared to black, one pixel a cycle, and busy
// stays high until the clear is through. Requests then queue in a two-entry
// buffer in front of the execution engine. A write is done from the engine's
// idle state; a read passes through a wait state for the registered data of
// the single frame store read port. A fill takes each stack pop through the
// pop, pop-wait and check states, then each in-frame neighbor of a painted
// pixel through the neighbor and neighbor-wait states, and a neighbor off the
// frame through the neighbor state alone; a pop of a pixel already painted
// goes back to the pop state after the check. Every request gives one result
// marked by done for a single cycle; the receiver must take it then.
module boundary_flood_fill #(
	parameter int FRAME_WIDTH  = 256,
	parameter int FRAME_HEIGHT = 256,
	parameter int STACK_DEPTH  = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  x_coord,
	input  logic [7:0]  y_coord,
	input  logic [23:0] pixel_colour,
	output logic        done,
	output logic [23:0] read_colour,
	output logic [16:0] filled_count,
	output logic        status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bff_pkg::*;

	logic [23:0] fill_q;
	logic [23:0] bnd_q;
	logic        cfg_we;
	cmd_t        cmd;
	logic        cmd_valid;
	logic        cmd_pop;
	logic        clearing;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = {8'd0, (paddr[2] == REG_BOUNDARY) ? bnd_q : fill_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= FILL_RESET;
			bnd_q  <= BOUNDARY_RESET;
		end else if (cfg_we) begin
			if (paddr[2] == REG_FILL) begin
				fill_q <= pwdata[23:0];
			end else begin
				bnd_q <= pwdata[23:0];
			end
		end
	end

	bff_front #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.pixel_colour (pixel_colour),
		.clearing     (clearing),
		.busy         (busy),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop)
	);

	bff_back #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.STACK_DEPTH  (STACK_DEPTH)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cmd_valid       (cmd_valid),
		.cmd_pop         (cmd_pop),
		.fill_colour     (fill_q),
		.boundary_colour (bnd_q),
		.clearing        (clearing),
		.done            (done),
		.read_colour     (read_colour),
		.filled_count    (filled_count),
		.status          (status)
	);

endmodule

// ===== hdl/bff_checker.sv =====
// ----------------------------------------------------------------------------
// bff_checker
// Port-level checks on results of the flood fill frame store.
// ----------------------------------------------------------------------------
module bff_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic [23:0] read_colour,
	input logic [16:0] filled_count,
	input logic        status,
	input logic        pready
);

	// Overflow only happens after at least one pixel was painted
	a_ovf_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> filled_count != 17'd0)
		else $error("overflow reported with zero count");

	// A fill result never carries read data
	a_fill_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && (filled_count != 17'd0) |-> read_colour == 24'd0)
		else $error("fill result carries read colour");

	// Overflow status never comes with read data
	a_ovf_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> read_colour == 24'd0)
		else $error("overflow result carries read colour");

	// Register port never stalls
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind boundary_flood_fill bff_checker u_bff_checker (.*);
